// ===== sv/ccp_pkg.sv =====
// ---------------------------------------------------------------------------
// ccp_pkg: shared types and codes for the constant pool parser
// Word layouts for both channels, the tag and result-kind codes and the
// parser phase encoding.
// ---------------------------------------------------------------------------
package ccp_pkg;

   // Input word: one stream byte plus the start-of-pool marker
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_type;

   // Result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] slot;
      logic [3:0]  tag;
      logic [31:0] value_a;
      logic [15:0] value_b;
      logic [7:0]  payload_byte;
      logic        last;
      logic [1:0]  error_code;
   } rsp_type;

   // Result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_ENTRY   = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_ILLEGAL    = 2'd1;
   localparam logic [1:0] ERR_WIDE_FINAL = 2'd2;

   // Entry tags
   localparam logic [3:0] TAG_NONE      = 4'd0;
   localparam logic [3:0] TAG_UTF8      = 4'd1;
   localparam logic [3:0] TAG_RESERVED  = 4'd2;
   localparam logic [3:0] TAG_INTEGER   = 4'd3;
   localparam logic [3:0] TAG_FLOAT     = 4'd4;
   localparam logic [3:0] TAG_LONG      = 4'd5;
   localparam logic [3:0] TAG_DOUBLE    = 4'd6;
   localparam logic [3:0] TAG_CLASS     = 4'd7;
   localparam logic [3:0] TAG_STRING    = 4'd8;
   localparam logic [3:0] TAG_FIELD_REF = 4'd9;
   localparam logic [3:0] TAG_NAME_TYPE = 4'd12;

   // Field byte counts
   localparam logic [2:0] SHORT_FIELD_BYTES = 3'd2;
   localparam logic [2:0] WORD_FIELD_BYTES  = 3'd4;

   // Parser phases
   typedef enum logic [7:0] {
      PH_CNT_HI  = 8'b0000_0001,
      PH_CNT_LO  = 8'b0000_0010,
      PH_TAG     = 8'b0000_0100,
      PH_FIELD   = 8'b0000_1000,
      PH_LOWORD  = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_DONE    = 8'b0100_0000,
      PH_HALT    = 8'b1000_0000
   } phase_type;

endpackage

// ===== sv/class_constant_pool_parser.sv =====
// ---------------------------------------------------------------------------
// class_constant_pool_parser: byte-serial constant pool parser
// Takes the constant pool one byte per word, reports the count, each entry,
// each UTF-8 payload byte and tag errors as result words.
// ---------------------------------------------------------------------------
// A byte waits in the input register, then parse logic loads its result register.
// Throughput: one byte per cycle unless a result stalls; the state update for
//   one byte is a single pass of field assembly and slot compare between
//   the two registers.
// Reset: synchronous; the parser waits for the count high byte, no result held.
module class_constant_pool_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ccp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ccp_pkg::rsp_type  rsp_data
);
   import ccp_pkg::*;

   // input register
   logic      in_vld_ff, in_vld_in;
   req_type   in_ff;
   // parser state
   phase_type   phase_ff, phase_in;
   logic [2:0]  byte_cnt_ff, byte_cnt_in;
   logic [15:0] pool_cnt_ff, pool_cnt_in;
   logic [15:0] slot_ff, slot_in;
   logic [3:0]  tag_ff, tag_in;
   logic [31:0] word_ff, word_in;
   logic [15:0] left_ff, left_in;
   // result register
   logic      rsp_vld_ff, rsp_vld_in;
   rsp_type   rsp_ff, rsp_in;

   logic        produce;
   logic        out_free;
   logic        adv;
   logic        accept;
   logic [7:0]  b;
   logic [2:0]  cnt_nx;
   logic [31:0] word_nx;
   logic [2:0]  need;
   logic [15:0] slot_p1, slot_p2;
   logic        done1, done2;
   logic [15:0] left_nx;
   logic [15:0] cnt_word;
   logic        wide_final;

   // handshake: a byte leaves the input register when its result has room
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign adv       = in_vld_ff && (!produce || out_free);
   assign req_stall = in_vld_ff && !adv;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept ? 1'b1 : (adv ? 1'b0 : in_vld_ff);

   // slot arithmetic shared by every completing entry
   assign b          = in_ff.data_byte;
   assign slot_p1    = slot_ff + 16'd1;
   assign slot_p2    = slot_ff + 16'd2;
   assign done1      = slot_p1 >= pool_cnt_ff;
   assign done2      = slot_p2 >= pool_cnt_ff;
   assign wide_final = ({1'b0, slot_ff} + 17'd1) >= {1'b0, pool_cnt_ff};
   assign cnt_nx     = byte_cnt_ff + 3'd1;
   assign word_nx    = {word_ff[23:0], b};
   assign left_nx    = left_ff - 16'd1;
   assign cnt_word   = {pool_cnt_ff[15:8], b};
   assign need       = (tag_ff == TAG_UTF8 || tag_ff == TAG_CLASS || tag_ff == TAG_STRING)
                       ? SHORT_FIELD_BYTES : WORD_FIELD_BYTES;

   // parse one byte
   always_comb begin
      phase_in    = phase_ff;
      byte_cnt_in = byte_cnt_ff;
      pool_cnt_in = pool_cnt_ff;
      slot_in     = slot_ff;
      tag_in      = tag_ff;
      word_in     = word_ff;
      left_in     = left_ff;
      produce     = 1'b0;
      rsp_in      = '0;
      if (in_ff.start_req) begin
         phase_in    = PH_CNT_LO;
         pool_cnt_in = {b, 8'h00};
         byte_cnt_in = '0;
         slot_in     = 16'd1;
         tag_in      = TAG_NONE;
         word_in     = '0;
         left_in     = '0;
      end else begin
         unique case (phase_ff)
            PH_CNT_HI: begin
               pool_cnt_in = {b, 8'h00};
               phase_in    = PH_CNT_LO;
            end
            PH_CNT_LO: begin
               pool_cnt_in    = cnt_word;
               slot_in        = 16'd1;
               produce        = 1'b1;
               rsp_in.kind    = KIND_HEADER;
               rsp_in.value_a = {16'h0000, cnt_word};
               rsp_in.last    = cnt_word <= 16'd1;
               phase_in       = (cnt_word <= 16'd1) ? PH_DONE : PH_TAG;
            end
            PH_TAG: begin
               if (b == {4'h0, TAG_NONE} || b == {4'h0, TAG_RESERVED} ||
                   b > {4'h0, TAG_NAME_TYPE}) begin
                  produce           = 1'b1;
                  rsp_in.kind       = KIND_ERROR;
                  rsp_in.slot       = slot_ff;
                  rsp_in.value_a    = {24'h0, b};
                  rsp_in.error_code = ERR_ILLEGAL;
                  phase_in          = PH_HALT;
               end else if ((b[3:0] == TAG_LONG || b[3:0] == TAG_DOUBLE) && wide_final) begin
                  produce           = 1'b1;
                  rsp_in.kind       = KIND_ERROR;
                  rsp_in.slot       = slot_ff;
                  rsp_in.tag        = b[3:0];
                  rsp_in.value_a    = {24'h0, b};
                  rsp_in.error_code = ERR_WIDE_FINAL;
                  phase_in          = PH_HALT;
               end else begin
                  tag_in      = b[3:0];
                  byte_cnt_in = '0;
                  word_in     = '0;
                  phase_in    = PH_FIELD;
               end
            end
            PH_FIELD: begin
               word_in     = word_nx;
               byte_cnt_in = cnt_nx;
               if (cnt_nx >= need) begin
                  byte_cnt_in = '0;
                  produce     = 1'b1;
                  rsp_in.kind = KIND_ENTRY;
                  rsp_in.slot = slot_ff;
                  rsp_in.tag  = tag_ff;
                  priority if (tag_ff == TAG_UTF8) begin
                     rsp_in.value_a = {16'h0000, word_nx[15:0]};
                     left_in        = word_nx[15:0];
                     if (word_nx[15:0] == 16'd0) begin
                        slot_in     = slot_p1;
                        rsp_in.last = done1;
                        phase_in    = done1 ? PH_DONE : PH_TAG;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else if (tag_ff == TAG_LONG || tag_ff == TAG_DOUBLE) begin
                     rsp_in.value_a = word_nx;
                     phase_in       = PH_LOWORD;
                  end else if (tag_ff == TAG_CLASS || tag_ff == TAG_STRING) begin
                     rsp_in.value_a = {16'h0000, word_nx[15:0]};
                     slot_in        = slot_p1;
                     rsp_in.last    = done1;
                     phase_in       = done1 ? PH_DONE : PH_TAG;
                  end else if (tag_ff >= TAG_FIELD_REF) begin
                     rsp_in.value_a = {16'h0000, word_nx[31:16]};
                     rsp_in.value_b = word_nx[15:0];
                     slot_in        = slot_p1;
                     rsp_in.last    = done1;
                     phase_in       = done1 ? PH_DONE : PH_TAG;
                  end else begin
                     rsp_in.value_a = word_nx;
                     slot_in        = slot_p1;
                     rsp_in.last    = done1;
                     phase_in       = done1 ? PH_DONE : PH_TAG;
                  end
               end
            end
            PH_LOWORD: begin
               word_in     = word_nx;
               byte_cnt_in = cnt_nx;
               if (cnt_nx >= WORD_FIELD_BYTES) begin
                  byte_cnt_in    = '0;
                  produce        = 1'b1;
                  rsp_in.kind    = KIND_ENTRY;
                  rsp_in.slot    = slot_p1;
                  rsp_in.tag     = TAG_NONE;
                  rsp_in.value_a = word_nx;
                  rsp_in.last    = done2;
                  slot_in        = slot_p2;
                  phase_in       = done2 ? PH_DONE : PH_TAG;
               end
            end
            PH_PAYLOAD: begin
               left_in             = left_nx;
               produce             = 1'b1;
               rsp_in.kind         = KIND_PAYLOAD;
               rsp_in.slot         = slot_ff;
               rsp_in.tag          = TAG_UTF8;
               rsp_in.payload_byte = b;
               if (left_nx == 16'd0) begin
                  slot_in     = slot_p1;
                  rsp_in.last = done1;
                  phase_in    = done1 ? PH_DONE : PH_TAG;
               end
            end
            PH_DONE, PH_HALT: begin
               // drop the byte
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   // result register: load on a produced result, drop once taken
   assign rsp_vld_in = (adv && produce) ? 1'b1 :
                       ((rsp_vld_ff && !rsp_stall) ? 1'b0 : rsp_vld_ff);

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         phase_ff    <= PH_CNT_HI;
         byte_cnt_ff <= '0;
         pool_cnt_ff <= '0;
         slot_ff     <= 16'd1;
         tag_ff      <= TAG_NONE;
         word_ff     <= '0;
         left_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (adv) begin
            phase_ff    <= phase_in;
            byte_cnt_ff <= byte_cnt_in;
            pool_cnt_ff <= pool_cnt_in;
            slot_ff     <= slot_in;
            tag_ff      <= tag_in;
            word_ff     <= word_in;
            left_ff     <= left_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (adv && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_header_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.kind == KIND_HEADER) |-> (rsp_ff.slot == 16'd0))
      else $error("header word carries a non-zero slot");

   a_error_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.kind == KIND_ERROR) |-> !rsp_ff.last)
      else $error("error word marked as last");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (adv && produce && rsp_in.kind == KIND_ERROR) |=> (phase_ff == PH_HALT))
      else $error("parser not halted after an error");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      (adv && in_ff.start_req) |=> (phase_ff == PH_CNT_LO && !$past(produce)))
      else $error("start byte did not restart the count");

   a_payload_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.kind == KIND_PAYLOAD) |-> (rsp_ff.tag == TAG_UTF8))
      else $error("payload word with a non-utf8 tag");

endmodule

// ===== tb/class_constant_pool_parser_test.sv =====
// ---------------------------------------------------------------------------
// class_constant_pool_parser_test: stream-level check of the pool parser
// Feeds byte streams of constant pools, some well formed and some broken,
// with random gaps and back-pressure. A behavioural copy of the parser
// predicts every result word, which is compared field by field on arrival.
// ---------------------------------------------------------------------------
module class_constant_pool_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ccp_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 37;

   // Tags the package leaves unnamed, and the first tag value past the table
   localparam logic [3:0] TAG_METHOD_REF = 4'd10;
   localparam logic [3:0] TAG_IFACE_REF  = 4'd11;
   localparam logic [7:0] FIRST_BAD_TAG  = 8'd13;

   typedef enum {FLAW_NONE, FLAW_CUT, FLAW_ILLEGAL, FLAW_WIDE_FINAL} flaw_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int idle_pct    = IDLE_PCT;
   int bytes_sent  = 0;
   int fail_count  = 0;
   int cycle_count = 0;
   int seen_kind [4] = '{0, 0, 0, 0};

   // Parser copy
   phase_type   cp_phase;
   logic [2:0]  cp_byte_cnt;
   logic [15:0] cp_count;
   logic [15:0] cp_slot;
   logic [3:0]  cp_tag;
   logic [31:0] cp_word;
   logic [15:0] cp_index;
   logic [15:0] cp_payload_left;
   logic        cp_halted;

   rsp_type awaited_results [$];

   class_constant_pool_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Hold off result words at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("status: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Parser copy: state handling and result prediction
   // -------------------------------------------------------------------------
   function automatic void clear_parser();
      cp_phase        = PH_CNT_HI;
      cp_byte_cnt     = '0;
      cp_count        = '0;
      cp_slot         = 16'd1;
      cp_tag          = TAG_NONE;
      cp_word         = '0;
      cp_index        = '0;
      cp_payload_left = '0;
      cp_halted       = 1'b0;
   endfunction

   function automatic void queue_result(input logic [1:0] kind, input logic [15:0] slot,
                                        input logic [3:0] tag, input logic [31:0] val_a,
                                        input logic [15:0] val_b, input logic [7:0] pbyte,
                                        input logic done, input logic [1:0] err);
      rsp_type r;
      r.kind         = kind;
      r.slot         = slot;
      r.tag          = tag;
      r.value_a      = val_a;
      r.value_b      = val_b;
      r.payload_byte = pbyte;
      r.last         = done;
      r.error_code   = err;
      awaited_results.push_back(r);
   endfunction

   // Move past n slots; report whether the pool is complete
   function automatic logic step_slots(input logic [15:0] n);
      cp_slot = cp_slot + n;
      if (cp_slot >= cp_count) begin
         cp_phase = PH_DONE;
         return 1'b1;
      end
      cp_phase = PH_TAG;
      return 1'b0;
   endfunction

   function automatic logic [2:0] field_len(input logic [3:0] tag);
      if (tag == TAG_UTF8 || tag == TAG_CLASS || tag == TAG_STRING)
         return SHORT_FIELD_BYTES;
      return WORD_FIELD_BYTES;
   endfunction

   function automatic void parse_byte(input req_type w);
      logic [7:0]  b;
      logic [15:0] s;
      logic        done;
      b = w.data_byte;
      // A start marker restarts parsing at the count high byte
      if (w.start_req) begin
         clear_parser();
         cp_count = {b, 8'h00};
         cp_phase = PH_CNT_LO;
         return;
      end
      if (cp_halted)
         return;
      case (cp_phase)
         PH_CNT_HI: begin
            cp_count = {b, 8'h00};
            cp_phase = PH_CNT_LO;
         end
         PH_CNT_LO: begin
            cp_count[7:0] = b;
            cp_slot       = 16'd1;
            done          = (cp_count <= 16'd1);
            cp_phase      = done ? PH_DONE : PH_TAG;
            queue_result(KIND_HEADER, 16'd0, TAG_NONE, {16'h0, cp_count}, 16'd0, 8'd0,
                         done, ERR_NONE);
         end
         PH_TAG: begin
            if (b == {4'h0, TAG_NONE} || b == {4'h0, TAG_RESERVED} ||
                b > {4'h0, TAG_NAME_TYPE}) begin
               cp_halted = 1'b1;
               queue_result(KIND_ERROR, cp_slot, TAG_NONE, {24'h0, b}, 16'd0, 8'd0,
                            1'b0, ERR_ILLEGAL);
            end else if ((b == {4'h0, TAG_LONG} || b == {4'h0, TAG_DOUBLE}) &&
                         ({1'b0, cp_slot} + 17'd1 >= {1'b0, cp_count})) begin
               cp_halted = 1'b1;
               queue_result(KIND_ERROR, cp_slot, b[3:0], {24'h0, b}, 16'd0, 8'd0,
                            1'b0, ERR_WIDE_FINAL);
            end else begin
               cp_tag      = b[3:0];
               cp_byte_cnt = '0;
               cp_word     = '0;
               cp_index    = '0;
               cp_phase    = PH_FIELD;
            end
         end
         PH_FIELD: begin
            cp_byte_cnt = cp_byte_cnt + 3'd1;
            cp_word     = {cp_word[23:0], b};
            cp_index    = {cp_index[7:0], b};
            if (cp_byte_cnt >= field_len(cp_tag)) begin
               cp_byte_cnt = '0;
               s           = cp_slot;
               case (cp_tag)
                  TAG_UTF8: begin
                     cp_payload_left = cp_index;
                     if (cp_payload_left == 16'd0) begin
                        done = step_slots(16'd1);
                     end else begin
                        done     = 1'b0;
                        cp_phase = PH_PAYLOAD;
                     end
                     queue_result(KIND_ENTRY, s, TAG_UTF8, {16'h0, cp_index}, 16'd0, 8'd0,
                                  done, ERR_NONE);
                  end
                  TAG_LONG, TAG_DOUBLE: begin
                     cp_phase = PH_LOWORD;
                     queue_result(KIND_ENTRY, s, cp_tag, cp_word, 16'd0, 8'd0, 1'b0,
                                  ERR_NONE);
                  end
                  TAG_CLASS, TAG_STRING: begin
                     done = step_slots(16'd1);
                     queue_result(KIND_ENTRY, s, cp_tag, {16'h0, cp_index}, 16'd0, 8'd0,
                                  done, ERR_NONE);
                  end
                  TAG_INTEGER, TAG_FLOAT: begin
                     done = step_slots(16'd1);
                     queue_result(KIND_ENTRY, s, cp_tag, cp_word, 16'd0, 8'd0, done,
                                  ERR_NONE);
                  end
                  default: begin
                     // References and name-and-type carry two indexes
                     done = step_slots(16'd1);
                     queue_result(KIND_ENTRY, s, cp_tag, {16'h0, cp_word[31:16]},
                                  cp_word[15:0], 8'd0, done, ERR_NONE);
                  end
               endcase
            end
         end
         PH_LOWORD: begin
            cp_byte_cnt = cp_byte_cnt + 3'd1;
            cp_word     = {cp_word[23:0], b};
            if (cp_byte_cnt >= WORD_FIELD_BYTES) begin
               cp_byte_cnt = '0;
               s           = cp_slot + 16'd1;
               done        = step_slots(16'd2);
               queue_result(KIND_ENTRY, s, TAG_NONE, cp_word, 16'd0, 8'd0, done, ERR_NONE);
            end
         end
         PH_PAYLOAD: begin
            s               = cp_slot;
            cp_payload_left = cp_payload_left - 16'd1;
            done            = (cp_payload_left == 16'd0) ? step_slots(16'd1) : 1'b0;
            queue_result(KIND_PAYLOAD, s, TAG_UTF8, 32'd0, 16'd0, b, done, ERR_NONE);
         end
         default: begin
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_kind[rsp_data.kind]++;
         if (awaited_results.size() == 0) begin
            $error("unexpected result word: kind %0d slot %0d tag %0d",
                   rsp_data.kind, rsp_data.slot, rsp_data.tag);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_data.kind));
            check_field("slot", 32'(want.slot), 32'(rsp_data.slot));
            check_field("tag", 32'(want.tag), 32'(rsp_data.tag));
            check_field("value_a", want.value_a, rsp_data.value_a);
            check_field("value_b", 32'(want.value_b), 32'(rsp_data.value_b));
            check_field("payload_byte", 32'(want.payload_byte),
                        32'(rsp_data.payload_byte));
            check_field("last", 32'(want.last), 32'(rsp_data.last));
            check_field("error_code", 32'(want.error_code), 32'(rsp_data.error_code));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   // Drive one byte word, hold it until accepted, then predict its results
   task automatic send_byte(input logic [7:0] b, input logic first);
      req_type w;
      w.data_byte = b;
      w.start_req = first;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      parse_byte(w);
   endtask

   function automatic logic [7:0] fill_byte(input int fill);
      if (fill < 0)
         return 8'($urandom_range(255));
      return fill[7:0];
   endfunction

   // Send a tag byte and its fields; fill below zero gives random contents
   task automatic send_entry(input logic [3:0] tag, input logic [15:0] utf_len,
                             input int fill);
      send_byte({4'h0, tag}, 1'b0);
      case (tag)
         TAG_UTF8: begin
            send_byte(utf_len[15:8], 1'b0);
            send_byte(utf_len[7:0], 1'b0);
            repeat (utf_len) send_byte(fill_byte(fill), 1'b0);
         end
         TAG_CLASS, TAG_STRING: repeat (2) send_byte(fill_byte(fill), 1'b0);
         TAG_LONG, TAG_DOUBLE:  repeat (8) send_byte(fill_byte(fill), 1'b0);
         default:               repeat (4) send_byte(fill_byte(fill), 1'b0);
      endcase
   endtask

   function automatic logic [3:0] pick_tag(input int slots_left);
      logic [3:0] t;
      do begin
         case ($urandom_range(10))
            0:       t = TAG_UTF8;
            1:       t = TAG_INTEGER;
            2:       t = TAG_FLOAT;
            3:       t = TAG_LONG;
            4:       t = TAG_DOUBLE;
            5:       t = TAG_CLASS;
            6:       t = TAG_STRING;
            7:       t = TAG_FIELD_REF;
            8:       t = TAG_METHOD_REF;
            9:       t = TAG_IFACE_REF;
            default: t = TAG_NAME_TYPE;
         endcase
      end while (slots_left < 2 && (t == TAG_LONG || t == TAG_DOUBLE));
      return t;
   endfunction

   function automatic logic [7:0] pick_bad_tag();
      case ($urandom_range(3))
         0:       return {4'h0, TAG_NONE};
         1:       return {4'h0, TAG_RESERVED};
         default: return 8'($urandom_range(FIRST_BAD_TAG, 255));
      endcase
   endfunction

   function automatic logic [15:0] pick_utf_len();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return 16'($urandom_range(4));
      if (r < 95)
         return 16'($urandom_range(5, 20));
      return 16'($urandom_range(21, 60));
   endfunction

   function automatic logic [15:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return 16'($urandom_range(1));
      if (r < 95)
         return 16'($urandom_range(2, 10));
      return 16'($urandom_range(256, 65535));
   endfunction

   // Send one pool from its start marker; large pools are always cut short
   task automatic send_pool(input logic [15:0] count, input flaw_type flaw);
      int         slot;
      int         made;
      int         limit;
      logic [3:0] t;
      send_byte(count[15:8], 1'b1);
      send_byte(count[7:0], 1'b0);
      limit = (flaw == FLAW_CUT || count > 32) ? $urandom_range(4) : count;
      slot  = 1;
      made  = 0;
      while (slot < count && made < limit) begin
         if (flaw == FLAW_WIDE_FINAL && slot == count - 1) begin
            t = $urandom_range(1) ? TAG_LONG : TAG_DOUBLE;
            send_byte({4'h0, t}, 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
            return;
         end
         t = pick_tag(count - slot);
         send_entry(t, pick_utf_len(), -1);
         slot += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
         made++;
      end
      if (flaw == FLAW_ILLEGAL) begin
         send_byte(pick_bad_tag(), 1'b0);
         send_byte(8'($urandom_range(255)), 1'b0);
      end else if ($urandom_range(9) == 0) begin
         send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   // Raw bytes with occasional start markers
   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
   endtask

   task automatic run_pools(input int byte_budget);
      int stop_at;
      int pick;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 78)
            send_pool(pick_count(), FLAW_NONE);
         else if (pick < 84)
            send_pool(pick_count(), FLAW_CUT);
         else if (pick < 90)
            send_pool(pick_count(), FLAW_ILLEGAL);
         else if (pick < 95)
            send_pool(16'($urandom_range(2, 8)), FLAW_WIDE_FINAL);
         else
            send_noise();
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Count without start after reset, empty pools, largest count, stray bytes
   task automatic test_header_edges();
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_entry(TAG_LONG, 16'd0, 8'hFF);
   endtask

   // Start marker in the middle of an entry's fields
   task automatic test_restart();
      send_byte(8'h00, 1'b1);
      send_byte(8'h05, 1'b0);
      send_byte({4'h0, TAG_INTEGER}, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h02, 1'b0);
      send_entry(TAG_STRING, 16'd0, 8'h00);
      send_byte(8'h55, 1'b0);
   endtask

   // One entry of every tag, including an empty string, in a single pool
   task automatic test_every_tag();
      send_byte(8'h00, 1'b1);
      send_byte(8'd15, 1'b0);
      send_entry(TAG_UTF8, 16'd2, 8'hFF);
      send_entry(TAG_UTF8, 16'd0, -1);
      send_entry(TAG_INTEGER, 16'd0, 8'hFF);
      send_entry(TAG_FLOAT, 16'd0, 8'h00);
      send_entry(TAG_LONG, 16'd0, 8'hFF);
      send_entry(TAG_DOUBLE, 16'd0, 8'h00);
      send_entry(TAG_CLASS, 16'd0, 8'hFF);
      send_entry(TAG_STRING, 16'd0, 8'h00);
      send_entry(TAG_FIELD_REF, 16'd0, -1);
      send_entry(TAG_METHOD_REF, 16'd0, -1);
      send_entry(TAG_IFACE_REF, 16'd0, 8'hFF);
      send_entry(TAG_NAME_TYPE, 16'd0, 8'h00);
      send_byte(8'h80, 1'b0);
   endtask

   // Illegal tags and wide entries in the final slot halt the parser
   task automatic test_bad_tags();
      logic [7:0] bad [4];
      bad = '{{4'h0, TAG_NONE}, {4'h0, TAG_RESERVED}, FIRST_BAD_TAG, 8'hFF};
      foreach (bad[i]) begin
         send_byte(8'h00, 1'b1);
         send_byte(8'h03, 1'b0);
         send_byte(bad[i], 1'b0);
         send_byte({4'h0, TAG_CLASS}, 1'b0);
      end
      send_byte(8'h00, 1'b1);
      send_byte(8'h02, 1'b0);
      send_byte({4'h0, TAG_LONG}, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h03, 1'b0);
      send_entry(TAG_CLASS, 16'd0, -1);
      send_byte({4'h0, TAG_DOUBLE}, 1'b0);
      send_byte(8'h01, 1'b0);
   endtask

   // Random pools with neither side idling
   task automatic test_back_to_back();
      idle_pct = 0;
      run_pools(150);
      idle_pct = IDLE_PCT;
   endtask

   // Random pools, broken pools and noise with random gaps and stalls
   task automatic test_random_pools();
      run_pools(550);
   endtask

   initial begin
      clear_parser();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_header_edges();
      test_restart();
      test_every_tag();
      test_bad_tags();
      test_back_to_back();
      test_random_pools();

      // Drain outstanding results, then watch for strays
      req_valid <= 1'b0;
      idle_pct = 0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d stream bytes across directed and random pools", bytes_sent);
      $display("checked %0d headers, %0d entries, %0d payload bytes, %0d error words",
               seen_kind[KIND_HEADER], seen_kind[KIND_ENTRY], seen_kind[KIND_PAYLOAD],
               seen_kind[KIND_ERROR]);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ccp_pkg.sv
sv/class_constant_pool_parser.sv
tb/class_constant_pool_parser_test.sv
